### hw/rtl/swrl_pkg.sv
// ============================================================================
// swrl_pkg
// Shared types and constants of the sliding-window rate limiter: field
// widths, register map, status and scope codes, sequencer states.
// ============================================================================
package swrl_pkg;

  // Field widths
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned MIN_LEN_W   = 16;
  localparam int unsigned SCOPE_W     = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_WIN_W    = 11;

  // Configuration port
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_MIN_LEN = 1'b1;

  // Register reset values
  localparam logic [STAMP_W-1:0]   RESET_WINDOW  = 32'd3000;
  localparam logic [MIN_LEN_W-1:0] RESET_MIN_LEN = 16'd8;

  // Scope codes; only configuration and debug read only are supported
  localparam logic [SCOPE_W-1:0] SCOPE_CONFIG        = 2'd0;
  localparam logic [SCOPE_W-1:0] SCOPE_DEBUG_RO      = 2'd1;
  localparam logic [SCOPE_W-1:0] SCOPE_DEBUG_WR      = 2'd2;
  localparam logic [SCOPE_W-1:0] SCOPE_DEBUG_WR_FULL = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACCEPTED          = 2'd0,
    STATUS_RATE_EXCEEDED     = 2'd1,
    STATUS_TOO_SHORT         = 2'd2,
    STATUS_SCOPE_UNSUPPORTED = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [STAMP_W-1:0]   window_ticks;
    logic [MIN_LEN_W-1:0] min_out_len;
  } cfg_t;

endpackage

### hw/rtl/swrl_if.sv
// ============================================================================
// swrl_if
// Valid/ready channels of the rate limiter: the request channel and the
// response channel.
// ============================================================================
interface swrl_req_if
  import swrl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STAMP_W-1:0]  now_ticks;
  logic [LEN_W-1:0]    out_len;
  logic [SCOPE_W-1:0]  scope;

  modport source (output valid, output now_ticks, output out_len, output scope,
                  input ready);
  modport sink   (input valid, input now_ticks, input out_len, input scope,
                  output ready);
endinterface

interface swrl_rsp_if
  import swrl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IN_WIN_W-1:0] in_window;

  modport source (output valid, output status, output in_window, input ready);
  modport sink   (input valid, input status, input in_window, output ready);
endinterface

### hw/rtl/swrl_regs.sv
// ============================================================================
// swrl_regs
// APB-style register file: window length and minimum output length.
// ============================================================================
module swrl_regs
  import swrl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ticks <= RESET_WINDOW;
      cfg.min_out_len  <= RESET_MIN_LEN;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW:  cfg.window_ticks <= pwdata;
        REG_MIN_LEN: cfg.min_out_len  <= pwdata[MIN_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_WINDOW:  prdata = cfg.window_ticks;
      REG_MIN_LEN: prdata = APB_DATA_W'(cfg.min_out_len);
      default:     prdata = '0;
    endcase
  end

endmodule

### hw/rtl/sliding_window_rate_limiter.sv
// ============================================================================
// sliding_window_rate_limiter
// Sliding-window log rate limiter: purges expired stamps, then admits or
// rejects each request and reports the number of stamps held.
// ============================================================================
// A request is taken when the block is idle and its response is loaded into
// an output register, so the next request may enter while a response waits.
// A request is taken in the idle state; the scan then pops the expired stamps
// from the head of the log: the log memory has one read port, and the
// purge checks one stamp per cycle through a single shared 32-bit
// subtractor, which first forms the earliest admissible time and then
// compares each head stamp against it. The final cycle also waits while the
// output register still holds an untaken response. No clearing pass is run
// after reset; only the values of held entries are ever used.
module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  swrl_req_if.sink              req,
  swrl_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);

  cfg_t cfg;

  state_t state, state_next;

  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   count, count_next;

  logic [STAMP_W-1:0] earliest;
  logic [STAMP_W-1:0] now_q;
  logic [LEN_W-1:0]   len_q;
  logic [SCOPE_W-1:0] scope_q;

  logic [STAMP_W-1:0] stamp_store [LOG_DEPTH];
  logic [STAMP_W-1:0] rd_data;
  logic               mem_we;

  logic [STAMP_W-1:0] sub_a, sub_b, sub_diff;
  logic               accept;
  logic               out_free;
  logic               log_full;
  logic               stop;
  logic               finish;
  status_t            status_new;

  swrl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign log_full  = (count == CNT_W'(LOG_DEPTH));

  // Shared subtractor: earliest time when idle, head stamp test when scanning
  assign sub_a    = (state == ST_IDLE) ? req.now_ticks : earliest;
  assign sub_b    = (state == ST_IDLE) ? cfg.window_ticks : rd_data;
  assign sub_diff = sub_a - sub_b;

  // Stop the purge at an empty log, a stored zero or a stamp inside the window
  assign stop = (count == '0) || (rd_data == '0) || sub_diff[STAMP_W-1];

  // Sequencer: pop one stamp per cycle, then push unless full, and respond
  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    mem_we     = 1'b0;
    finish     = 1'b0;
    status_new = STATUS_ACCEPTED;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stop) begin
          head_next  = (head == IDX_W'(LOG_DEPTH - 1)) ? '0 : head + 1'b1;
          count_next = count - 1'b1;
        end else if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
          if (log_full) begin
            status_new = STATUS_RATE_EXCEEDED;
          end else begin
            mem_we     = 1'b1;
            tail_next  = (tail == IDX_W'(LOG_DEPTH - 1)) ? '0 : tail + 1'b1;
            count_next = count + 1'b1;
            if (len_q < LEN_W'(cfg.min_out_len)) begin
              status_new = STATUS_TOO_SHORT;
            end else if (scope_q inside {SCOPE_CONFIG, SCOPE_DEBUG_RO}) begin
              status_new = STATUS_ACCEPTED;
            end else begin
              status_new = STATUS_SCOPE_UNSUPPORTED;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Capture the request and its earliest admissible time
  always_ff @(posedge clk) begin
    if (accept) begin
      earliest <= sub_diff;
      now_q    <= req.now_ticks;
      len_q    <= req.out_len;
      scope_q  <= req.scope;
    end
  end

  // Stamp log: push at the tail, read ahead at the next head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_store[tail] <= now_q;
    end
    rd_data <= stamp_store[head_next];
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.status    <= status_new;
      rsp.in_window <= IN_WIN_W'(count_next);
    end
  end

`ifndef SYNTHESIS
  // A partly filled log never has head and tail together
  assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count != CNT_W'(LOG_DEPTH)) |-> (head != tail))
    else $error("log pointers disagree with held count");

  // The held count never passes the log depth
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LOG_DEPTH))
    else $error("held count beyond log depth");

  // An accepted request always starts a purge scan
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN))
    else $error("request accepted without scan");

  // A full log never grows on finish
  assert property (@(posedge clk) disable iff (rst)
    finish && log_full |=> rsp.valid && (rsp.status == STATUS_RATE_EXCEEDED)
      && (count == CNT_W'(LOG_DEPTH)))
    else $error("full log not rejected");
`endif

endmodule
